// ----- src/sdsh_pkg.sv -----
// Shared types and constants of the SD-card SPI host sequencer.
`timescale 1ns / 1ps
package sdsh_pkg;

   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned BYTE_CNT_W  = 10;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_MISO  = 2'd1;
   localparam logic [1:0] MODE_DELAY = 2'd2;
   localparam logic [1:0] MODE_WBYTE = 2'd3;

   localparam logic [1:0] REQ_INIT  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   localparam logic [2:0] K_XFER  = 3'd0;
   localparam logic [2:0] K_DELAY = 3'd1;
   localparam logic [2:0] K_READ  = 3'd2;
   localparam logic [2:0] K_NEEDW = 3'd3;
   localparam logic [2:0] K_DONE  = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOCARD  = 3'd1;
   localparam logic [2:0] ST_INIT    = 3'd2;
   localparam logic [2:0] ST_TIMEOUT = 3'd3;
   localparam logic [2:0] ST_WRITE   = 3'd4;
   localparam logic [2:0] ST_READ    = 3'd5;

   localparam logic [1:0] CK_UNKNOWN = 2'd0;
   localparam logic [1:0] CK_SDSC    = 2'd1;
   localparam logic [1:0] CK_SDHC    = 2'd2;

   localparam logic [5:0] CMD0  = 6'd0;
   localparam logic [5:0] CMD8  = 6'd8;
   localparam logic [5:0] CMD16 = 6'd16;
   localparam logic [5:0] CMD17 = 6'd17;
   localparam logic [5:0] CMD24 = 6'd24;
   localparam logic [5:0] CMD41 = 6'd41;
   localparam logic [5:0] CMD55 = 6'd55;
   localparam logic [5:0] CMD58 = 6'd58;

   localparam logic [2:0] CSR_POWER_UP   = 3'd0;
   localparam logic [2:0] CSR_ATTEMPTS   = 3'd1;
   localparam logic [2:0] CSR_RETRY      = 3'd2;
   localparam logic [2:0] CSR_INIT_TO    = 3'd3;
   localparam logic [2:0] CSR_TOKEN_TO   = 3'd4;
   localparam logic [2:0] CSR_POLLS      = 3'd5;
   localparam logic [2:0] CSR_BUSY_TO    = 3'd6;

   localparam logic [7:0] BYTE_IDLE   = 8'hFF;
   localparam logic [7:0] TOKEN_START = 8'hFE;
   localparam logic [7:0] CRC_CMD0    = 8'h95;
   localparam logic [7:0] CRC_CMD8    = 8'h87;
   localparam logic [7:0] CRC_DUMMY   = 8'h01;
   localparam logic [7:0] CMD_PREFIX  = 8'h40;
   localparam logic [7:0] R1_IDLE     = 8'h01;
   localparam logic [7:0] DRESP_MASK  = 8'h1F;
   localparam logic [7:0] DRESP_OK    = 8'h05;
   localparam logic [31:0] ARG_CMD8   = 32'h000001AA;
   localparam logic [31:0] ARG_HCS    = 32'h40000000;

   typedef enum logic [4:0] {
      PH_IDLE, PH_POWER_DELAY, PH_IDLE_CLOCKS, PH_RETRY_DELAY, PH_CMD_SEND,
      PH_CMD_POLL, PH_R7, PH_OCR, PH_TAIL_LOW, PH_TAIL_HIGH, PH_INIT_DELAY,
      PH_TOKEN, PH_TOKEN_DELAY, PH_READ_DATA, PH_READ_CRC, PH_WR_GAP,
      PH_WR_TOKEN, PH_WR_NEED, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY,
      PH_BUSY_DELAY
   } phase_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  request;
      logic [31:0] block_number;
      logic [7:0]  miso_byte;
      logic [7:0]  write_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] mosi_byte;
      logic       chip_select_high;
      logic [9:0] wait_ms;
      logic [7:0] read_byte;
      logic       last_byte;
      logic [2:0] status;
      logic       high_capacity;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic rsp_item_type mk_xfer(logic [7:0] b, logic cs);
      rsp_item_type r;
      r = '0;
      r.kind = K_XFER;
      r.mosi_byte = b;
      r.chip_select_high = cs;
      return r;
   endfunction

   function automatic rsp_item_type mk_delay(logic [9:0] ms);
      rsp_item_type r;
      r = '0;
      r.kind = K_DELAY;
      r.wait_ms = ms;
      return r;
   endfunction

endpackage

// ----- src/sdsh_req_if.sv -----
// Channel interfaces for the request and response transfers.
`timescale 1ns / 1ps
interface sdsh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [1:0]  request;
   logic [31:0] block_number;
   logic [7:0]  miso_byte;
   logic [7:0]  write_byte;
   modport source (output valid, mode, request, block_number, miso_byte, write_byte,
                   input ready);
   modport sink (input valid, mode, request, block_number, miso_byte, write_byte,
                 output ready);
endinterface

interface sdsh_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] mosi_byte;
   logic       chip_select_high;
   logic [9:0] wait_ms;
   logic [7:0] read_byte;
   logic       last_byte;
   logic [2:0] status;
   logic       high_capacity;
   modport source (output valid, kind, mosi_byte, chip_select_high, wait_ms, read_byte,
                   last_byte, status, high_capacity, input ready);
   modport sink (input valid, kind, mosi_byte, chip_select_high, wait_ms, read_byte,
                 last_byte, status, high_capacity, output ready);
endinterface

// ----- src/sdsh_result_fifo.sv -----
// Result queue taking up to two results a cycle and handing out one while the output is ready.
`timescale 1ns / 1ps
module sdsh_result_fifo #(
   parameter int unsigned DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sdsh_pkg::push_type           push,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         out_valid,
   input  logic                         out_ready,
   output sdsh_pkg::rsp_item_type       out_item
);
   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   sdsh_pkg::rsp_item_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;
   logic [PW-1:0] wr_next;

   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + PW'(1);
   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);
   assign count     = count_ff;
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_next] <= push.second;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff + CW'(push.count)) <= CW'(DEPTH))
      else $error("result queue overflow");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("queue count lost a pop");
   a_empty_no_valid: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !out_valid)
      else $error("valid from empty queue");
endmodule

// ----- src/sdsh_engine.sv -----
// Sequencer state, configuration registers and per-event next-action logic.
`timescale 1ns / 1ps
module sdsh_engine #(
   parameter int unsigned RESPONSE_POLLS = 8,
   parameter int unsigned QDEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  sdsh_pkg::req_item_type        in_item,
   input  logic [$clog2(QDEPTH+1)-1:0]   q_count,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [15:0]                   csr_wdata,
   output sdsh_pkg::push_type            push
);
   localparam int unsigned CW = $clog2(QDEPTH + 1);
   localparam int unsigned BCW = sdsh_pkg::BYTE_CNT_W;
   localparam logic [BCW-1:0] LAST_IDX = BCW'(sdsh_pkg::BLOCK_BYTES - 1);
   localparam logic [BCW:0] BLK = (BCW+1)'(sdsh_pkg::BLOCK_BYTES);

   // configuration
   logic [9:0]  pud_ff;
   logic [7:0]  att_cfg_ff, retry_ff;
   logic [15:0] init_to_ff, token_to_ff, polls_ff, busy_to_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pud_ff      <= 10'd100;
         att_cfg_ff  <= 8'd10;
         retry_ff    <= 8'd10;
         init_to_ff  <= 16'd2000;
         token_to_ff <= 16'd200;
         polls_ff    <= 16'd1000;
         busy_to_ff  <= 16'd10000;
      end else if (csr_we) begin
         unique case (csr_index)
            sdsh_pkg::CSR_POWER_UP: pud_ff      <= csr_wdata[9:0];
            sdsh_pkg::CSR_ATTEMPTS: att_cfg_ff  <= csr_wdata[7:0];
            sdsh_pkg::CSR_RETRY:    retry_ff    <= csr_wdata[7:0];
            sdsh_pkg::CSR_INIT_TO:  init_to_ff  <= csr_wdata;
            sdsh_pkg::CSR_TOKEN_TO: token_to_ff <= csr_wdata;
            sdsh_pkg::CSR_POLLS:    polls_ff    <= csr_wdata;
            sdsh_pkg::CSR_BUSY_TO:  busy_to_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic                   ev_valid_ff;
   sdsh_pkg::req_item_type ev_ff;

   assign in_ready = (CW'(q_count) + (ev_valid_ff ? CW'(2) : CW'(0))) <= CW'(QDEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) ev_valid_ff <= 1'b0;
      else       ev_valid_ff <= in_valid && in_ready;
   end
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) ev_ff <= in_item;
   end

   // sequencer state
   sdsh_pkg::phase_type phase_ff, phase_in;
   logic [BCW-1:0] bcnt_ff, bcnt_in;
   logic [7:0]     att_ff, att_in;
   logic [15:0]    elapsed_ff, elapsed_in, poll_ff, poll_in;
   logic           ver2_ff, ver2_in, tail_ends_ff, tail_ends_in;
   logic [1:0]     card_ff, card_in;
   logic [31:0]    arg_ff, arg_in;
   logic [7:0]     resp_ff, resp_in;
   logic [5:0]     cmd_ff, cmd_in;
   logic [2:0]     pend_ff, pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sdsh_pkg::PH_IDLE;
         bcnt_ff      <= '0;
         att_ff       <= '0;
         elapsed_ff   <= '0;
         poll_ff      <= '0;
         ver2_ff      <= 1'b0;
         card_ff      <= sdsh_pkg::CK_UNKNOWN;
         arg_ff       <= '0;
         resp_ff      <= 8'hFF;
         cmd_ff       <= sdsh_pkg::CMD0;
         tail_ends_ff <= 1'b0;
         pend_ff      <= sdsh_pkg::ST_OK;
      end else begin
         phase_ff     <= phase_in;
         bcnt_ff      <= bcnt_in;
         att_ff       <= att_in;
         elapsed_ff   <= elapsed_in;
         poll_ff      <= poll_in;
         ver2_ff      <= ver2_in;
         card_ff      <= card_in;
         arg_ff       <= arg_in;
         resp_ff      <= resp_in;
         cmd_ff       <= cmd_in;
         tail_ends_ff <= tail_ends_in;
         pend_ff      <= pend_in;
      end
   end

   // chained action flags, resolved in order within one pass
   logic f_resp, f_tail, f_reset, f_round, f_poll, f_cmd, f_tl, f_done;
   logic [5:0]  cmd_code;
   logic [31:0] cmd_arg;
   logic        tl_ends;
   logic [2:0]  tl_st, done_st;
   logic        have_main, have_pre;
   sdsh_pkg::rsp_item_type main_r, pre_r;
   logic [7:0]  cbyte;
   logic [16:0] esum;

   always_comb begin
      phase_in = phase_ff;   bcnt_in = bcnt_ff;    att_in = att_ff;
      elapsed_in = elapsed_ff; poll_in = poll_ff;  ver2_in = ver2_ff;
      card_in = card_ff;     arg_in = arg_ff;      resp_in = resp_ff;
      cmd_in = cmd_ff;       tail_ends_in = tail_ends_ff; pend_in = pend_ff;
      f_resp = 1'b0; f_tail = 1'b0; f_reset = 1'b0; f_round = 1'b0;
      f_poll = 1'b0; f_cmd = 1'b0; f_tl = 1'b0; f_done = 1'b0;
      cmd_code = sdsh_pkg::CMD0; cmd_arg = '0; tl_ends = 1'b0;
      tl_st = sdsh_pkg::ST_OK; done_st = sdsh_pkg::ST_OK;
      have_main = 1'b0; have_pre = 1'b0; main_r = '0; pre_r = '0;
      cbyte = sdsh_pkg::BYTE_IDLE;
      esum = '0;

      if (ev_valid_ff) begin
         unique case (ev_ff.mode)
            sdsh_pkg::MODE_START: begin
               if (phase_ff == sdsh_pkg::PH_IDLE && ev_ff.request != 2'd3) begin
                  if (ev_ff.request == sdsh_pkg::REQ_INIT) begin
                     card_in = sdsh_pkg::CK_UNKNOWN;
                     ver2_in = 1'b0;
                     att_in  = '0;
                     phase_in = sdsh_pkg::PH_POWER_DELAY;
                     have_main = 1'b1;
                     main_r = sdsh_pkg::mk_delay(pud_ff);
                  end else begin
                     f_cmd = 1'b1;
                     cmd_code = (ev_ff.request == sdsh_pkg::REQ_READ) ?
                                sdsh_pkg::CMD17 : sdsh_pkg::CMD24;
                     cmd_arg = (card_ff == sdsh_pkg::CK_SDHC) ? ev_ff.block_number :
                               {ev_ff.block_number[22:0], 9'd0};
                  end
               end
            end
            sdsh_pkg::MODE_DELAY: begin
               unique case (phase_ff)
                  sdsh_pkg::PH_POWER_DELAY: begin
                     bcnt_in = '0;
                     phase_in = sdsh_pkg::PH_IDLE_CLOCKS;
                     have_main = 1'b1;
                     main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b1);
                  end
                  sdsh_pkg::PH_RETRY_DELAY: f_reset = 1'b1;
                  sdsh_pkg::PH_INIT_DELAY: begin
                     esum = {1'b0, elapsed_ff} + 17'(retry_ff);
                     elapsed_in = esum[16] ? 16'hFFFF : esum[15:0];
                     if (elapsed_in < init_to_ff) begin
                        f_cmd = 1'b1; cmd_code = sdsh_pkg::CMD55; cmd_arg = '0;
                     end else begin
                        f_done = 1'b1; done_st = sdsh_pkg::ST_INIT;
                     end
                  end
                  sdsh_pkg::PH_TOKEN_DELAY: begin
                     elapsed_in = elapsed_ff + 16'd1;
                     f_round = 1'b1;
                  end
                  sdsh_pkg::PH_BUSY_DELAY: begin
                     if (elapsed_ff >= busy_to_ff) begin
                        f_done = 1'b1; done_st = sdsh_pkg::ST_TIMEOUT;
                     end else begin
                        elapsed_in = elapsed_ff + 16'd1;
                        phase_in = sdsh_pkg::PH_WR_BUSY;
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                     end
                  end
                  default: ;
               endcase
            end
            sdsh_pkg::MODE_WBYTE: begin
               if (phase_ff == sdsh_pkg::PH_WR_NEED) begin
                  phase_in = sdsh_pkg::PH_WR_DATA;
                  have_main = 1'b1;
                  main_r = sdsh_pkg::mk_xfer(ev_ff.write_byte, 1'b0);
               end
            end
            sdsh_pkg::MODE_MISO: begin
               unique case (phase_ff)
                  sdsh_pkg::PH_IDLE_CLOCKS: begin
                     bcnt_in = bcnt_ff + BCW'(1);
                     if (bcnt_in < BCW'(16)) begin
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b1);
                     end else f_reset = 1'b1;
                  end
                  sdsh_pkg::PH_CMD_SEND: begin
                     bcnt_in = bcnt_ff + BCW'(1);
                     if (bcnt_in <= BCW'(6)) begin
                        unique case (bcnt_in[2:0])
                           3'd1: cbyte = sdsh_pkg::CMD_PREFIX | {2'b00, cmd_ff};
                           3'd2: cbyte = arg_ff[31:24];
                           3'd3: cbyte = arg_ff[23:16];
                           3'd4: cbyte = arg_ff[15:8];
                           3'd5: cbyte = arg_ff[7:0];
                           3'd6: cbyte = (cmd_ff == sdsh_pkg::CMD0) ? sdsh_pkg::CRC_CMD0 :
                                         (cmd_ff == sdsh_pkg::CMD8) ? sdsh_pkg::CRC_CMD8 :
                                         sdsh_pkg::CRC_DUMMY;
                           default: cbyte = sdsh_pkg::BYTE_IDLE;
                        endcase
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(cbyte, 1'b0);
                     end else begin
                        poll_in = '0;
                        phase_in = sdsh_pkg::PH_CMD_POLL;
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                     end
                  end
                  sdsh_pkg::PH_CMD_POLL: begin
                     resp_in = ev_ff.miso_byte;
                     poll_in = poll_ff + 16'd1;
                     if (!ev_ff.miso_byte[7] || poll_in >= 16'(RESPONSE_POLLS)) begin
                        f_resp = 1'b1;
                     end else begin
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                     end
                  end
                  sdsh_pkg::PH_R7, sdsh_pkg::PH_OCR: begin
                     if (phase_ff == sdsh_pkg::PH_OCR && bcnt_ff == '0 && ev_ff.miso_byte[6])
                        card_in = sdsh_pkg::CK_SDHC;
                     bcnt_in = bcnt_ff + BCW'(1);
                     if (bcnt_in < BCW'(4)) begin
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                     end else f_tl = 1'b1;
                  end
                  sdsh_pkg::PH_TAIL_LOW: begin
                     if (tail_ends_ff) begin
                        f_done = 1'b1; done_st = pend_ff;
                     end else begin
                        phase_in = sdsh_pkg::PH_TAIL_HIGH;
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b1);
                     end
                  end
                  sdsh_pkg::PH_TAIL_HIGH: f_tail = 1'b1;
                  sdsh_pkg::PH_TOKEN: begin
                     poll_in = poll_ff + 16'd1;
                     if (ev_ff.miso_byte == sdsh_pkg::TOKEN_START) begin
                        bcnt_in = '0;
                        phase_in = sdsh_pkg::PH_READ_DATA;
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                     end else if (ev_ff.miso_byte != sdsh_pkg::BYTE_IDLE) begin
                        f_tl = 1'b1; tl_ends = 1'b1; tl_st = sdsh_pkg::ST_READ;
                     end else f_poll = 1'b1;
                  end
                  sdsh_pkg::PH_READ_DATA: begin
                     have_pre = 1'b1;
                     pre_r = '0;
                     pre_r.kind = sdsh_pkg::K_READ;
                     pre_r.read_byte = ev_ff.miso_byte;
                     pre_r.last_byte = bcnt_ff == LAST_IDX;
                     if (bcnt_ff == LAST_IDX) begin
                        bcnt_in = '0;
                        phase_in = sdsh_pkg::PH_READ_CRC;
                     end else bcnt_in = bcnt_ff + BCW'(1);
                     have_main = 1'b1;
                     main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                  end
                  sdsh_pkg::PH_READ_CRC: begin
                     bcnt_in = bcnt_ff + BCW'(1);
                     if (bcnt_in < BCW'(2)) begin
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                     end else f_tl = 1'b1;
                  end
                  sdsh_pkg::PH_WR_GAP: begin
                     phase_in = sdsh_pkg::PH_WR_TOKEN;
                     have_main = 1'b1;
                     main_r = sdsh_pkg::mk_xfer(sdsh_pkg::TOKEN_START, 1'b0);
                  end
                  sdsh_pkg::PH_WR_TOKEN, sdsh_pkg::PH_WR_DATA: begin
                     bcnt_in = (phase_ff == sdsh_pkg::PH_WR_TOKEN) ? '0 : bcnt_ff + BCW'(1);
                     if ({1'b0, bcnt_in} < BLK && !(phase_ff == sdsh_pkg::PH_WR_DATA &&
                                                    bcnt_ff == LAST_IDX)) begin
                        phase_in = sdsh_pkg::PH_WR_NEED;
                        have_main = 1'b1;
                        main_r = '0;
                        main_r.kind = sdsh_pkg::K_NEEDW;
                        main_r.last_byte = bcnt_in == LAST_IDX;
                     end else begin
                        bcnt_in = '0;
                        phase_in = sdsh_pkg::PH_WR_CRC;
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                     end
                  end
                  sdsh_pkg::PH_WR_CRC: begin
                     bcnt_in = bcnt_ff + BCW'(1);
                     if (bcnt_in >= BCW'(2)) phase_in = sdsh_pkg::PH_WR_RESP;
                     have_main = 1'b1;
                     main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                  end
                  sdsh_pkg::PH_WR_RESP: begin
                     if ((ev_ff.miso_byte & sdsh_pkg::DRESP_MASK) != sdsh_pkg::DRESP_OK) begin
                        f_tl = 1'b1; tl_ends = 1'b1; tl_st = sdsh_pkg::ST_WRITE;
                     end else begin
                        elapsed_in = '0;
                        phase_in = sdsh_pkg::PH_WR_BUSY;
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
                     end
                  end
                  sdsh_pkg::PH_WR_BUSY: begin
                     if (ev_ff.miso_byte == 8'h00) begin
                        phase_in = sdsh_pkg::PH_BUSY_DELAY;
                        have_main = 1'b1;
                        main_r = sdsh_pkg::mk_delay(10'd1);
                     end else f_tl = 1'b1;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      // command response
      if (f_resp) begin
         unique case (cmd_ff)
            sdsh_pkg::CMD8: begin
               if (resp_in == sdsh_pkg::R1_IDLE) begin
                  ver2_in = 1'b1;
                  bcnt_in = '0;
                  phase_in = sdsh_pkg::PH_R7;
                  have_main = 1'b1;
                  main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
               end else f_tl = 1'b1;
            end
            sdsh_pkg::CMD55: begin
               f_cmd = 1'b1; cmd_code = sdsh_pkg::CMD41;
               cmd_arg = ver2_ff ? sdsh_pkg::ARG_HCS : '0;
            end
            sdsh_pkg::CMD58: begin
               if (resp_in == 8'h00) begin
                  bcnt_in = '0;
                  phase_in = sdsh_pkg::PH_OCR;
                  have_main = 1'b1;
                  main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
               end else f_tl = 1'b1;
            end
            sdsh_pkg::CMD17: begin
               if (resp_in != 8'h00) begin
                  f_tl = 1'b1; tl_ends = 1'b1; tl_st = sdsh_pkg::ST_READ;
               end else begin
                  elapsed_in = '0;
                  f_round = 1'b1;
               end
            end
            sdsh_pkg::CMD24: begin
               if (resp_in != 8'h00) begin
                  f_tl = 1'b1; tl_ends = 1'b1; tl_st = sdsh_pkg::ST_WRITE;
               end else begin
                  phase_in = sdsh_pkg::PH_WR_GAP;
                  have_main = 1'b1;
                  main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
               end
            end
            default: f_tl = 1'b1;
         endcase
      end

      // after the closing byte
      if (f_tail) begin
         unique case (cmd_ff)
            sdsh_pkg::CMD0: begin
               if (resp_ff == sdsh_pkg::R1_IDLE) begin
                  f_cmd = 1'b1; cmd_code = sdsh_pkg::CMD8; cmd_arg = sdsh_pkg::ARG_CMD8;
               end else begin
                  att_in = att_ff + 8'd1;
                  phase_in = sdsh_pkg::PH_RETRY_DELAY;
                  have_main = 1'b1;
                  main_r = sdsh_pkg::mk_delay(10'(retry_ff));
               end
            end
            sdsh_pkg::CMD8: begin
               elapsed_in = '0;
               f_cmd = 1'b1; cmd_code = sdsh_pkg::CMD55; cmd_arg = '0;
            end
            sdsh_pkg::CMD41: begin
               if (resp_ff == 8'h00) begin
                  card_in = sdsh_pkg::CK_SDSC;
                  f_cmd = 1'b1;
                  cmd_code = ver2_ff ? sdsh_pkg::CMD58 : sdsh_pkg::CMD16;
                  cmd_arg = ver2_ff ? '0 : 32'(sdsh_pkg::BLOCK_BYTES);
               end else begin
                  phase_in = sdsh_pkg::PH_INIT_DELAY;
                  have_main = 1'b1;
                  main_r = sdsh_pkg::mk_delay(10'(retry_ff));
               end
            end
            sdsh_pkg::CMD58: begin
               if (card_ff == sdsh_pkg::CK_SDSC) begin
                  f_cmd = 1'b1; cmd_code = sdsh_pkg::CMD16;
                  cmd_arg = 32'(sdsh_pkg::BLOCK_BYTES);
               end else begin
                  f_done = 1'b1; done_st = sdsh_pkg::ST_OK;
               end
            end
            sdsh_pkg::CMD16: begin
               f_done = 1'b1;
               done_st = (resp_ff == 8'h00) ? sdsh_pkg::ST_OK : sdsh_pkg::ST_INIT;
            end
            default: begin
               f_done = 1'b1; done_st = sdsh_pkg::ST_OK;
            end
         endcase
      end

      if (f_reset) begin
         if (att_ff >= att_cfg_ff) begin
            f_done = 1'b1; done_st = sdsh_pkg::ST_NOCARD;
         end else begin
            f_cmd = 1'b1; cmd_code = sdsh_pkg::CMD0; cmd_arg = '0;
         end
      end

      if (f_round) begin
         if (elapsed_in >= token_to_ff) begin
            f_tl = 1'b1; tl_ends = 1'b1; tl_st = sdsh_pkg::ST_TIMEOUT;
         end else begin
            poll_in = '0;
            f_poll = 1'b1;
         end
      end

      if (f_poll) begin
         have_main = 1'b1;
         if (poll_in >= polls_ff) begin
            phase_in = sdsh_pkg::PH_TOKEN_DELAY;
            main_r = sdsh_pkg::mk_delay(10'd1);
         end else begin
            phase_in = sdsh_pkg::PH_TOKEN;
            main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
         end
      end

      if (f_cmd) begin
         cmd_in = cmd_code;
         arg_in = cmd_arg;
         bcnt_in = '0;
         phase_in = sdsh_pkg::PH_CMD_SEND;
         have_main = 1'b1;
         main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
      end

      if (f_tl) begin
         tail_ends_in = tl_ends;
         pend_in = tl_st;
         phase_in = sdsh_pkg::PH_TAIL_LOW;
         have_main = 1'b1;
         main_r = sdsh_pkg::mk_xfer(sdsh_pkg::BYTE_IDLE, 1'b0);
      end

      if (f_done) begin
         phase_in = sdsh_pkg::PH_IDLE;
         have_main = 1'b1;
         main_r = '0;
         main_r.kind = sdsh_pkg::K_DONE;
         main_r.chip_select_high = 1'b1;
         main_r.status = done_st;
         main_r.high_capacity = card_in == sdsh_pkg::CK_SDHC;
      end
   end

   always_comb begin
      push = '0;
      if (have_pre) begin
         push.count = 2'd2;
         push.first = pre_r;
         push.second = main_r;
      end else if (have_main) begin
         push.count = 2'd1;
         push.first = main_r;
      end
   end

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd1 && push.first.kind == sdsh_pkg::K_DONE) |=>
      (phase_ff == sdsh_pkg::PH_IDLE))
      else $error("finished without returning to idle");
   a_pair_is_read: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.first.kind == sdsh_pkg::K_READ &&
                                push.second.kind == sdsh_pkg::K_XFER))
      else $error("two results that are not a read byte and transfer");
   a_push_needs_event: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> ev_valid_ff)
      else $error("result without an event");
endmodule

// ----- src/sd_spi_host_sequencer.sv -----
// Top level of the SD-card SPI-mode host sequencer.
// An event is registered at acceptance, and its results are then written into the
// result queue, from which they transfer out.
// Throughput: one event per cycle while the input is ready; each event yields at most
// two results, drained one per cycle while the output is ready, from an eight-entry result
// queue that sets the input ready. Reset (synchronous, active high) clears the sequencer to
// idle, the queue to empty and the configuration registers to their defaults.
`timescale 1ns / 1ps
module sd_spi_host_sequencer #(
   parameter int unsigned RESPONSE_POLLS = 8
) (
   input  logic        clock,
   input  logic        reset,
   sdsh_req_if.sink    req_ch,
   sdsh_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int unsigned QDEPTH = 8;

   sdsh_pkg::req_item_type         in_item;
   sdsh_pkg::rsp_item_type         out_item;
   sdsh_pkg::push_type             push;
   logic [$clog2(QDEPTH+1)-1:0]    q_count;

   assign in_item.mode         = req_ch.mode;
   assign in_item.request      = req_ch.request;
   assign in_item.block_number = req_ch.block_number;
   assign in_item.miso_byte    = req_ch.miso_byte;
   assign in_item.write_byte   = req_ch.write_byte;

   sdsh_engine #(.RESPONSE_POLLS(RESPONSE_POLLS), .QDEPTH(QDEPTH)) u_engine (
      .clock(clock), .reset(reset),
      .in_valid(req_ch.valid), .in_ready(req_ch.ready), .in_item(in_item),
      .q_count(q_count),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .push(push)
   );

   sdsh_result_fifo #(.DEPTH(QDEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(push), .count(q_count),
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_item(out_item)
   );

   assign rsp_ch.kind             = out_item.kind;
   assign rsp_ch.mosi_byte        = out_item.mosi_byte;
   assign rsp_ch.chip_select_high = out_item.chip_select_high;
   assign rsp_ch.wait_ms          = out_item.wait_ms;
   assign rsp_ch.read_byte        = out_item.read_byte;
   assign rsp_ch.last_byte        = out_item.last_byte;
   assign rsp_ch.status           = out_item.status;
   assign rsp_ch.high_capacity    = out_item.high_capacity;
endmodule
